// ----- hw/rtl/esig_pkg.sv -----
package esig_pkg;

    localparam int FIELD_W   = 16;
    localparam int DEGREE_W  = 5;
    localparam int PI_DEG_W  = 2;
    localparam int PI_SLOTS  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PI_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PI_PRIME = 2'd2;

    localparam logic [FIELD_W-1:0] LT_COUNT_RST = 16'd17;
    localparam logic [FIELD_W-1:0] PI_COUNT_RST = 16'd10;
    localparam logic [FIELD_W-1:0] PI_PRIME_RST = 16'd11;

    localparam logic [PI_DEG_W-1:0] PI_DEG_MIN = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] lt_count;
        logic [FIELD_W-1:0] pi_count;
        logic [FIELD_W-1:0] pi_prime;
    } cfg_t;

    typedef struct packed {
        logic                              err;
        logic [DEGREE_W-1:0]               degree;
        logic [FIELD_W-1:0]                lt_step;
        logic [FIELD_W-1:0]                lt_start;
        logic [PI_DEG_W-1:0]               pi_degree;
        logic [PI_SLOTS-1:0][FIELD_W-1:0]  pi_pos;
    } cmd_t;

    // (pos + step) mod modulus, both operands already below modulus
    function automatic logic [FIELD_W-1:0] mod_advance(
        input logic [FIELD_W-1:0] pos,
        input logic [FIELD_W-1:0] step,
        input logic [FIELD_W-1:0] modulus
    );
        logic [FIELD_W:0] s;
        s = {1'b0, pos} + {1'b0, step};
        if (s >= {1'b0, modulus})
        begin
            s = s - {1'b0, modulus};
        end
        return s[FIELD_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/esig_if.sv -----
interface esig_tuple_if;
    logic        valid;
    logic        ready;
    logic [4:0]  degree;
    logic [15:0] lt_step;
    logic [15:0] lt_start;
    logic [1:0]  pi_degree;
    logic [15:0] pi_step;
    logic [15:0] pi_start;

    modport source (
        output valid, degree, lt_step, lt_start, pi_degree, pi_step, pi_start,
        input  ready
    );
    modport sink (
        input  valid, degree, lt_step, lt_start, pi_degree, pi_step, pi_start,
        output ready
    );
endinterface

interface esig_result_if #(parameter int INDEX_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] symbol_index;
    logic                   last;
    logic                   error;

    modport source (output valid, symbol_index, last, error, input ready);
    modport sink (input valid, symbol_index, last, error, output ready);
endinterface

interface esig_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/esig_front.sv -----
module esig_front #(
    parameter int INDEX_WIDTH = 16,
    parameter int MAX_DEGREE  = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    esig_tuple_if.sink        tuple,
    input  esig_pkg::cfg_t    cfg_vals,
    input  logic              q_full,
    output logic              q_push,
    output esig_pkg::cmd_t    q_data
);
    import esig_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_WALK = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [FIELD_W-1:0]  pos_reg, pos_next;
    logic [FIELD_W-1:0]  tries_reg, tries_next;
    logic [1:0]          slot_reg, slot_next;
    logic [FIELD_W-1:0]  step_reg, step_next;

    logic                accept;
    logic                bad_tuple;
    logic [32:0]         span;
    logic                overflow;
    logic [FIELD_W-1:0]  pos_adv;

    assign tuple.ready = (state_reg == F_IDLE);
    assign accept      = tuple.valid && tuple.ready;

    assign span     = 33'(cfg_vals.lt_count) + 33'(cfg_vals.pi_count);
    assign overflow = span > (33'(1) << INDEX_WIDTH);

    assign bad_tuple = (tuple.degree == '0) || (32'(tuple.degree) > MAX_DEGREE) ||
                       (tuple.pi_degree < PI_DEG_MIN) ||
                       (tuple.lt_start >= cfg_vals.lt_count) ||
                       (tuple.lt_step >= cfg_vals.lt_count) ||
                       (tuple.pi_start >= cfg_vals.pi_prime) ||
                       (tuple.pi_step == '0) ||
                       (tuple.pi_step >= cfg_vals.pi_prime) ||
                       (cfg_vals.pi_count == '0) || overflow;

    assign pos_adv = mod_advance(pos_reg, step_reg, cfg_vals.pi_prime);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        tries_next = tries_reg;
        slot_next  = slot_reg;
        step_next  = step_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.err       = bad_tuple;
                    cmd_next.degree    = tuple.degree;
                    cmd_next.lt_step   = tuple.lt_step;
                    cmd_next.lt_start  = tuple.lt_start;
                    cmd_next.pi_degree = tuple.pi_degree;
                    step_next          = tuple.pi_step;
                    pos_next           = tuple.pi_start;
                    tries_next         = '0;
                    slot_next          = '0;
                    state_next         = bad_tuple ? F_PUSH : F_WALK;
                end
            end
            F_WALK:
            begin
                if (pos_reg >= cfg_vals.pi_count)
                begin
                    if (tries_reg >= cfg_vals.pi_prime)
                    begin
                        cmd_next.err = 1'b1;
                        state_next   = F_PUSH;
                    end
                    else
                    begin
                        pos_next   = pos_adv;
                        tries_next = tries_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd_next.pi_pos[slot_reg] = pos_reg;
                    if (slot_reg == cmd_reg.pi_degree - 2'd1)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        pos_next   = pos_adv;
                        tries_next = '0;
                    end
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_data = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        tries_reg <= tries_next;
        slot_reg  <= slot_next;
        step_reg  <= step_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_WALK) |-> (slot_reg < PI_SLOTS[1:0]))
        else $error("PI slot out of range");

endmodule

// ----- hw/rtl/esig_queue.sv -----
module esig_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  esig_pkg::cmd_t    push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output esig_pkg::cmd_t    head_data
);
    import esig_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

// ----- hw/rtl/esig_back.sv -----
module esig_back #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    esig_result_if.source     result,
    input  esig_pkg::cfg_t    cfg_vals,
    input  logic              head_valid,
    input  esig_pkg::cmd_t    head_data,
    output logic              pop
);
    import esig_pkg::*;

    logic                    active_reg, active_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [DEGREE_W-1:0]     lt_left_reg, lt_left_next;
    logic [FIELD_W-1:0]      pos_reg, pos_next;
    logic [1:0]              pi_sel_reg, pi_sel_next;

    logic                    out_valid_reg, out_valid_next;
    logic [INDEX_WIDTH-1:0]  out_index_reg, out_index_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_err_reg, out_err_next;

    logic                    produce;
    logic                    pi_final;
    logic [FIELD_W:0]        pi_sum;

    assign result.valid        = out_valid_reg;
    assign result.symbol_index = out_index_reg;
    assign result.last         = out_last_reg;
    assign result.error        = out_err_reg;

    assign produce  = active_reg && (!out_valid_reg || result.ready);
    assign pop      = !active_reg && head_valid;
    assign pi_final = (pi_sel_reg == cmd_reg.pi_degree - 2'd1);
    assign pi_sum   = {1'b0, cfg_vals.lt_count} + {1'b0, cmd_reg.pi_pos[pi_sel_reg]};

    always_comb
    begin
        active_next    = active_reg;
        cmd_next       = cmd_reg;
        lt_left_next   = lt_left_reg;
        pos_next       = pos_reg;
        pi_sel_next    = pi_sel_reg;
        out_valid_next = (out_valid_reg && !result.ready);
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (pop)
        begin
            active_next  = 1'b1;
            cmd_next     = head_data;
            lt_left_next = head_data.degree;
            pos_next     = head_data.lt_start;
            pi_sel_next  = '0;
        end
        else if (produce)
        begin
            out_valid_next = 1'b1;
            if (cmd_reg.err)
            begin
                out_index_next = '0;
                out_last_next  = 1'b1;
                out_err_next   = 1'b1;
                active_next    = 1'b0;
            end
            else if (lt_left_reg != '0)
            begin
                out_index_next = INDEX_WIDTH'(pos_reg);
                out_last_next  = 1'b0;
                out_err_next   = 1'b0;
                lt_left_next   = lt_left_reg - 1'b1;
                pos_next       = mod_advance(pos_reg, cmd_reg.lt_step, cfg_vals.lt_count);
            end
            else
            begin
                out_index_next = INDEX_WIDTH'(pi_sum);
                out_last_next  = pi_final;
                out_err_next   = 1'b0;
                if (pi_final)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    pi_sel_next = pi_sel_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        lt_left_reg   <= lt_left_next;
        pos_reg       <= pos_next;
        pi_sel_reg    <= pi_sel_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_last_reg && out_index_reg == '0))
        else $error("error result without last or with nonzero index");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> (out_valid_reg && out_last_reg))
        else $error("transaction ended without a last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !cmd_reg.err) |-> (pi_sel_reg < cmd_reg.pi_degree))
        else $error("PI select ran past the PI degree");

endmodule

// ----- hw/rtl/encoding_symbol_index_generator_unit.sv -----
// Channel  Modport  Payload
// tuple    sink     degree, lt_step, lt_start, pi_degree, pi_step, pi_start
// result   source   symbol_index, last, error
// cfg      sink     index, data (0 lt_count, 1 pi_count, 2 pi_prime)
//
// Front: accepts a tuple, then walks one PI step per cycle (pi_degree plus
// skipped values), then pushes once the queue has room. Back: loads a queued
// tuple, then emits one index per cycle while the result is not stalled,
// degree + pi_degree results (one on error).
// Reset clears control only; cfg registers return to 17, 10, 11.
// A stalled result holds in the output register while the back loads the
// next queued tuple and the front walks the one after it.
module encoding_symbol_index_generator_unit #(
    parameter int INDEX_WIDTH = 16,
    parameter int MAX_DEGREE  = 30
) (
    input  logic           clk,
    input  logic           rst_n,
    esig_tuple_if.sink     tuple,
    esig_result_if.source  result,
    esig_cfg_if.sink       cfg
);
    import esig_pkg::*;

    cfg_t  cfg_vals_reg, cfg_vals_next;
    logic  q_push, q_full, q_pop, q_head_valid;
    cmd_t  q_push_data, q_head_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_vals_next = cfg_vals_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LT_COUNT: cfg_vals_next.lt_count = cfg.data;
                REG_PI_COUNT: cfg_vals_next.pi_count = cfg.data;
                REG_PI_PRIME: cfg_vals_next.pi_prime = cfg.data;
                default:      cfg_vals_next = cfg_vals_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_vals_reg.lt_count <= LT_COUNT_RST;
            cfg_vals_reg.pi_count <= PI_COUNT_RST;
            cfg_vals_reg.pi_prime <= PI_PRIME_RST;
        end
        else
        begin
            cfg_vals_reg <= cfg_vals_next;
        end
    end

    esig_front #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tuple    (tuple),
        .cfg_vals (cfg_vals_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    esig_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    esig_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .result     (result),
        .cfg_vals   (cfg_vals_reg),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import esig_pkg::*;

    localparam int MAX_DEG = 30;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [DEGREE_W-1:0] degree;
        logic [FIELD_W-1:0]  lt_step;
        logic [FIELD_W-1:0]  lt_start;
        logic [PI_DEG_W-1:0] pi_degree;
        logic [FIELD_W-1:0]  pi_step;
        logic [FIELD_W-1:0]  pi_start;
    } tuple_t;

    typedef struct packed {
        logic [FIELD_W-1:0] symbol_index;
        logic               last;
        logic               error;
    } index_result_t;

    logic clk;
    logic rst_n;

    esig_tuple_if  tuple_ch ();
    esig_result_if #(.INDEX_WIDTH(FIELD_W)) result_ch ();
    esig_cfg_if    cfg_ch ();

    encoding_symbol_index_generator_unit #(
        .INDEX_WIDTH (FIELD_W),
        .MAX_DEGREE  (MAX_DEG)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tuple  (tuple_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // register copies used for prediction
    logic [FIELD_W-1:0] lt_count_q;
    logic [FIELD_W-1:0] pi_count_q;
    logic [FIELD_W-1:0] pi_prime_q;

    index_result_t pending_indices [$];
    index_result_t got_index;
    index_result_t want_index;
    int            mismatch_count;
    int            send_idle_pct;
    int            recv_idle_pct;

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got_index = '{result_ch.symbol_index, result_ch.last, result_ch.error};
            if (pending_indices.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected transaction index=%0d last=%b error=%b",
                             $realtime, got_index.symbol_index, got_index.last,
                             got_index.error);
                mismatch_count++;
            end
            else
            begin
                want_index = pending_indices.pop_front();
                if (got_index.symbol_index !== want_index.symbol_index
                    || got_index.last !== want_index.last
                    || got_index.error !== want_index.error)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: exp index %0d last %b error %b, got %0d %b %b",
                                 $realtime, want_index.symbol_index, want_index.last,
                                 want_index.error, got_index.symbol_index,
                                 got_index.last, got_index.error);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic [FIELD_W-1:0] wrap_add(
        input logic [FIELD_W-1:0] pos,
        input logic [FIELD_W-1:0] step,
        input logic [FIELD_W-1:0] modulus
    );
        logic [FIELD_W:0] sum;
        sum = {1'b0, pos} + {1'b0, step};
        if (sum >= {1'b0, modulus})
            sum = sum - {1'b0, modulus};
        return sum[FIELD_W-1:0];
    endfunction

    // expected indices of one tuple under the current register values
    function automatic void predict_indices(input tuple_t t);
        index_result_t walk [$];
        logic [FIELD_W-1:0] lt_pos;
        logic [FIELD_W-1:0] pi_pos;
        logic [FIELD_W:0]   span;
        logic [FIELD_W-1:0] pi_index;
        int                 tries;
        bit                 rejected;

        span = {1'b0, lt_count_q} + {1'b0, pi_count_q};
        rejected = t.degree == 0 || t.degree > MAX_DEG || t.pi_degree < PI_DEG_MIN
            || t.lt_start >= lt_count_q || t.lt_step >= lt_count_q
            || t.pi_start >= pi_prime_q || t.pi_step == 0 || t.pi_step >= pi_prime_q
            || pi_count_q == 0 || span - 1 > {1'b0, {FIELD_W{1'b1}}};

        if (!rejected)
        begin
            lt_pos = t.lt_start;
            for (int j = 0; j < t.degree; j++)
            begin
                if (j > 0)
                    lt_pos = wrap_add(lt_pos, t.lt_step, lt_count_q);
                walk.insert(walk.size(), '{lt_pos, 1'b0, 1'b0});
            end
            pi_pos = t.pi_start;
            for (int j = 0; j < t.pi_degree && !rejected; j++)
            begin
                if (j > 0)
                    pi_pos = wrap_add(pi_pos, t.pi_step, pi_prime_q);
                tries = 0;
                while (pi_pos >= pi_count_q && !rejected)
                begin
                    if (tries >= pi_prime_q)
                        rejected = 1'b1;
                    else
                    begin
                        pi_pos = wrap_add(pi_pos, t.pi_step, pi_prime_q);
                        tries++;
                    end
                end
                pi_index = lt_count_q + pi_pos;
                walk.insert(walk.size(), '{pi_index, 1'b0, 1'b0});
            end
        end

        if (rejected)
            pending_indices.insert(pending_indices.size(), '{'0, 1'b1, 1'b1});
        else
        begin
            walk[walk.size()-1].last = 1'b1;
            foreach (walk[k])
                pending_indices.insert(pending_indices.size(), walk[k]);
        end
    endfunction

    function automatic bit prime_check(input int n);
        if (n < 2)
            return 0;
        for (int f = 2; f * f <= n; f++)
            if (n % f == 0)
                return 0;
        return 1;
    endfunction

    function automatic int prime_above(input int n);
        int p;
        p = n + 1;
        while (!prime_check(p))
            p++;
        return p;
    endfunction

    task automatic send_tuple(input tuple_t t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tuple_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tuple_ch.valid     <= 1'b1;
        tuple_ch.degree    <= t.degree;
        tuple_ch.lt_step   <= t.lt_step;
        tuple_ch.lt_start  <= t.lt_start;
        tuple_ch.pi_degree <= t.pi_degree;
        tuple_ch.pi_step   <= t.pi_step;
        tuple_ch.pi_start  <= t.pi_start;
        @(posedge clk);
        while (!tuple_ch.ready)
            @(posedge clk);
        predict_indices(t);
    endtask

    task automatic send_fields(
        input int d, input int a, input int b,
        input int d1, input int a1, input int b1
    );
        tuple_t t;
        t.degree    = DEGREE_W'(d);
        t.lt_step   = FIELD_W'(a);
        t.lt_start  = FIELD_W'(b);
        t.pi_degree = PI_DEG_W'(d1);
        t.pi_step   = FIELD_W'(a1);
        t.pi_start  = FIELD_W'(b1);
        send_tuple(t);
    endtask

    // lower valid, wait for every expected index, then let the block settle
    task automatic drain_results();
        @(negedge clk);
        tuple_ch.valid <= 1'b0;
        while (pending_indices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FIELD_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_LT_COUNT: lt_count_q = value;
            REG_PI_COUNT: pi_count_q = value;
            REG_PI_PRIME: pi_prime_q = value;
            default: ;
        endcase
    endtask

    task automatic set_registers(input int lt_count, input int pi_count,
                                 input int pi_prime);
        write_register(REG_LT_COUNT, FIELD_W'(lt_count));
        write_register(REG_PI_COUNT, FIELD_W'(pi_count));
        write_register(REG_PI_PRIME, FIELD_W'(pi_prime));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random_tuples(input int count);
        tuple_t t;
        int     roll;
        repeat (count)
        begin
            t.degree    = DEGREE_W'($urandom_range(MAX_DEG, 1));
            t.lt_step   = FIELD_W'($urandom_range(lt_count_q - 1, 0));
            t.lt_start  = FIELD_W'($urandom_range(lt_count_q - 1, 0));
            t.pi_degree = PI_DEG_W'($urandom_range(3, 2));
            t.pi_step   = FIELD_W'($urandom_range(pi_prime_q - 1, 1));
            t.pi_start  = FIELD_W'($urandom_range(pi_prime_q - 1, 0));
            roll = $urandom_range(99);
            if (roll >= 92)
            begin
                t.degree    = DEGREE_W'($urandom_range(31));
                t.lt_step   = FIELD_W'($urandom_range(16'hFFFF));
                t.lt_start  = FIELD_W'($urandom_range(16'hFFFF));
                t.pi_degree = PI_DEG_W'($urandom_range(3));
                t.pi_step   = FIELD_W'($urandom_range(16'hFFFF));
                t.pi_start  = FIELD_W'($urandom_range(16'hFFFF));
            end
            else if (roll >= 80)
            begin
                case ($urandom_range(5))
                    0: t.degree    = DEGREE_W'($urandom_range(31));
                    1: t.lt_step   = FIELD_W'($urandom_range(16'hFFFF));
                    2: t.lt_start  = FIELD_W'($urandom_range(16'hFFFF));
                    3: t.pi_degree = PI_DEG_W'($urandom_range(1));
                    4: t.pi_step   = FIELD_W'($urandom_range(16'hFFFF));
                    default: t.pi_start = FIELD_W'($urandom_range(16'hFFFF));
                endcase
            end
            send_tuple(t);
        end
    endtask

    task automatic test_default_registers();
        send_fields(1, 0, 0, 2, 1, 0);
        send_fields(30, 16, 16, 3, 10, 10);     // PI start needs a skip
        send_fields(0, 1, 1, 2, 1, 0);          // zero degree
        send_fields(31, 1, 1, 2, 1, 0);         // degree above max
        send_fields(4, 3, 2, 0, 1, 0);          // PI degree too small
        send_fields(4, 3, 2, 1, 1, 0);
        send_fields(2, 1, 17, 2, 1, 0);         // LT start out of range
        send_fields(2, 17, 1, 2, 1, 0);         // LT step out of range
        send_fields(2, 1, 1, 3, 1, 11);         // PI start out of range
        send_fields(2, 1, 1, 3, 0, 1);          // PI step zero
        send_fields(2, 1, 1, 3, 11, 1);         // PI step out of range
        send_fields(5, 0, 9, 3, 3, 9);          // LT step zero repeats
        send_fields(31, 16'hFFFF, 16'hFFFF, 3, 16'hFFFF, 16'hFFFF);
        drain_results();
    endtask

    task automatic test_register_extremes();
        set_registers(16'hFFFF, 1, 2);
        send_fields(30, 16'hFFFE, 16'hFFFE, 3, 1, 1);
        send_fields(1, 16'hFFFE, 16'hFFFF, 2, 1, 0);
        drain_results();
        set_registers(16'hFFFF, 2, 3);          // index overflow
        send_fields(1, 0, 0, 2, 1, 0);
        drain_results();
        set_registers(3, 16'hFFFD, 16'hFFFF);
        send_fields(5, 2, 2, 3, 16'hFFFE, 16'hFFFE);
        send_fields(30, 1, 0, 3, 1, 16'hFFFC);
        drain_results();
        set_registers(3, 1, 12);                // composite modulus
        send_fields(2, 1, 0, 2, 2, 1);          // skip never lands
        send_fields(2, 1, 0, 3, 1, 5);
        send_fields(2, 1, 0, 2, 3, 1);          // skip never lands
        drain_results();
        set_registers(17, 0, 11);               // empty PI set
        send_fields(3, 1, 1, 2, 1, 0);
        drain_results();
        set_registers(0, 10, 11);
        send_fields(3, 0, 0, 2, 1, 0);
        drain_results();
        set_registers(17, 10, 0);
        send_fields(3, 1, 1, 2, 0, 0);
        drain_results();
    endtask

    task automatic test_random_sender_idle();
        int pc;
        pc = $urandom_range(60, 1);
        set_registers($urandom_range(300, 3), pc, prime_above(pc));
        run_random_tuples(69);
        drain_results();
    endtask

    task automatic test_random_receiver_idle();
        int pc;
        send_idle_pct = 47;
        recv_idle_pct = 22;
        pc = $urandom_range(500, 1);
        set_registers($urandom_range(65000, 30000), pc, prime_above(pc));
        run_random_tuples(69);
        drain_results();
    endtask

    task automatic test_random_no_idle();
        int pc;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pc = $urandom_range(20, 1);
        set_registers($urandom_range(8, 3), pc, prime_above(pc));
        run_random_tuples(69);
        drain_results();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        tuple_ch.valid = 1'b0;
        tuple_ch.degree    = '0;
        tuple_ch.lt_step   = '0;
        tuple_ch.lt_start  = '0;
        tuple_ch.pi_degree = '0;
        tuple_ch.pi_step   = '0;
        tuple_ch.pi_start  = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        lt_count_q      = LT_COUNT_RST;
        pi_count_q      = PI_COUNT_RST;
        pi_prime_q      = PI_PRIME_RST;
        mismatch_count  = 0;
        send_idle_pct   = 22;
        recv_idle_pct   = 47;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_default_registers();
        test_register_extremes();
        test_random_sender_idle();
        test_random_receiver_idle();
        test_random_no_idle();

        if (mismatch_count == 0 && pending_indices.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/esig_pkg.sv
hw/rtl/esig_if.sv
hw/rtl/esig_front.sv
hw/rtl/esig_queue.sv
hw/rtl/esig_back.sv
hw/rtl/encoding_symbol_index_generator_unit.sv
tb/sv/tb_top.sv
